[rtl/prrs_pkg.sv]
// Shared types, constants and helpers for the priority round-robin slot picker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package prrs_pkg;

  localparam int SLOT_W = 4;   // hardware slot number
  localparam int PRIO_W = 8;   // priority byte
  localparam int WORD_W = 32;  // region start, end and permission words
  localparam int REL_W  = 4;   // slot index relative to the first dynamic slot

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_INVAL = 1'b1
  } cmd_t;

  // start request from the control FSM to the scan sequencer
  typedef struct packed {
    logic              start;
    logic [REL_W-1:0]  ptr;
    logic [PRIO_W-1:0] prio;
  } scan_req_t;

  // scan outcome, valid for one cycle while done is high
  typedef struct packed {
    logic             done;
    logic             found;
    logic [REL_W-1:0] target;
  } scan_res_t;

  // write and clear request into the priority store
  typedef struct packed {
    logic              wr_en;
    logic              clear;
    logic [REL_W-1:0]  rel;
    logic [PRIO_W-1:0] prio;
  } store_wr_t;

  // advance a relative slot index, wrap after the last dynamic slot
  function automatic logic [REL_W-1:0] rel_wrap_inc(input logic [REL_W-1:0] rel,
                                                    input logic [REL_W-1:0] last);
    logic [REL_W-1:0] res;
    if (rel == last) begin
      res = '0;
    end else begin
      res = rel + REL_W'(1);
    end
    return res;
  endfunction

endpackage

[rtl/prrs_prio_store.sv]
// Priority byte store, one entry per dynamic slot, with a bulk clear.
// Depends on prrs_pkg (store_wr_t, widths).
module prrs_prio_store #(
  parameter int DEPTH = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prrs_pkg::store_wr_t          wr,
  input  logic [prrs_pkg::REL_W-1:0]   rd_rel,
  output logic [prrs_pkg::PRIO_W-1:0]  rd_prio
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [prrs_pkg::PRIO_W-1:0] prio_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        prio_r[i] <= '0;
      end
    end else if (wr.wr_en) begin
      prio_r[wr.rel[IDX_W-1:0]] <= wr.prio;
    end
  end

  assign rd_prio = prio_r[rd_rel[IDX_W-1:0]];

endmodule

[rtl/prrs_scan_seq.sv]
// Scan sequencer: walks the dynamic slots one per cycle through a single
// priority comparator. Depends on prrs_pkg (scan_req_t, scan_res_t, rel_wrap_inc).
module prrs_scan_seq #(
  parameter int DEPTH = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prrs_pkg::scan_req_t          req,
  input  logic [prrs_pkg::PRIO_W-1:0]  rd_prio,
  output logic [prrs_pkg::REL_W-1:0]   rd_rel,
  output prrs_pkg::scan_res_t          res
);

  localparam int RW = prrs_pkg::REL_W;
  localparam logic [RW-1:0] LAST_REL = RW'(DEPTH - 1);

  logic                        busy_r,  busy_nxt;
  logic [RW-1:0]               idx_r,   idx_nxt;
  logic [RW-1:0]               cnt_r,   cnt_nxt;
  logic [RW-1:0]               ptr_r,   ptr_nxt;
  logic [prrs_pkg::PRIO_W-1:0] prio_r,  prio_nxt;
  logic                        hit;
  logic                        last;

  // the shared compare unit
  assign hit  = rd_prio < prio_r;
  assign last = cnt_r == LAST_REL;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    ptr_nxt  = ptr_r;
    prio_nxt = prio_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = req.ptr;
      cnt_nxt  = '0;
      ptr_nxt  = req.ptr;
      prio_nxt = req.prio;
    end else if (busy_r) begin
      if (hit || last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = prrs_pkg::rel_wrap_inc(idx_r, LAST_REL);
        cnt_nxt = cnt_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    ptr_r  <= ptr_nxt;
    prio_r <= prio_nxt;
  end

  assign rd_rel    = idx_r;
  assign res.done  = busy_r && (hit || last);
  assign res.found = hit;
  // fall back to the slot just before the pointer
  assign res.target = hit ? idx_r : ((ptr_r == '0) ? LAST_REL : ptr_r - RW'(1));

endmodule

[rtl/priority_round_robin_region_slots_unit.sv]
// Operation: a push scans up to N dynamic slots (7 by default) from the pointer
//   through the single priority comparator, stepped once per slot, which sets the
//   scan length; ST_DONE then loads the output register once it is free.
//   Invalidate, and push with no dynamic slots, skip the scan.
// Flow: one word at a time; in_stall holds the next word until the result is loaded.
// Reset (synchronous, rst_n low): pointer to the first dynamic slot, all priorities 0.
module priority_round_robin_region_slots_unit #(
  parameter int FIRST_DYNAMIC_SLOT = 5,
  parameter int TOTAL_SLOTS        = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [prrs_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [prrs_pkg::WORD_W-1:0]   in_region_start,
  input  logic [prrs_pkg::WORD_W-1:0]   in_region_end,
  input  logic [prrs_pkg::WORD_W-1:0]   in_region_perm,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prrs_pkg::SLOT_W-1:0]   out_slot,
  output logic [prrs_pkg::WORD_W-1:0]   out_start,
  output logic [prrs_pkg::WORD_W-1:0]   out_end,
  output logic [prrs_pkg::WORD_W-1:0]   out_perm,
  output logic                          out_slot_enable,
  output logic                          out_found_lower
);

  localparam int RW = prrs_pkg::REL_W;
  localparam int SW = prrs_pkg::SLOT_W;
  localparam int WW = prrs_pkg::WORD_W;
  localparam int PW = prrs_pkg::PRIO_W;

  // number of dynamic slots; the store keeps at least one entry
  localparam int DYN_COUNT   = (TOTAL_SLOTS > FIRST_DYNAMIC_SLOT) ?
                               (TOTAL_SLOTS - FIRST_DYNAMIC_SLOT) : 0;
  localparam int STORE_DEPTH = (DYN_COUNT > 0) ? DYN_COUNT : 1;
  localparam logic [RW-1:0] LAST_REL   = RW'(STORE_DEPTH - 1);
  localparam logic [SW-1:0] FIRST_SLOT = SW'(FIRST_DYNAMIC_SLOT);
  localparam logic          HAS_DYN    = (DYN_COUNT > 0);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // relative next-slot pointer; the slot number is this plus FIRST_DYNAMIC_SLOT
  logic [RW-1:0] ptr_r, ptr_nxt;

  // the word in flight: payload and its pending result
  logic [WW-1:0] start_r, start_nxt;
  logic [WW-1:0] end_r,   end_nxt;
  logic [WW-1:0] perm_r,  perm_nxt;
  logic [SW-1:0] slot_r,  slot_nxt;
  logic          en_r,    en_nxt;
  logic          found_r, found_nxt;

  // hold the effective priority of the word being scanned
  logic [PW-1:0] prio_hold_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_slot_r;
  logic [WW-1:0] out_start_r;
  logic [WW-1:0] out_end_r;
  logic [WW-1:0] out_perm_r;
  logic          out_en_r;
  logic          out_found_r;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic [PW-1:0]       prio_eff;
  prrs_pkg::scan_req_t scan_req;
  prrs_pkg::scan_res_t scan_res;
  prrs_pkg::store_wr_t store_wr;
  logic [RW-1:0]       rd_rel;
  logic [PW-1:0]       rd_prio;

  // one word at a time; the output register lets the next word in while a
  // result still waits downstream
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DONE) && out_free;

  // priority 0 counts as 1
  assign prio_eff = (in_priority_req == '0) ? PW'(1) : in_priority_req;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    perm_nxt  = perm_r;
    slot_nxt  = slot_r;
    en_nxt    = en_r;
    found_nxt = found_r;

    scan_req.start = 1'b0;
    scan_req.ptr   = ptr_r;
    scan_req.prio  = prio_eff;

    store_wr.wr_en = 1'b0;
    store_wr.clear = 1'b0;
    store_wr.rel   = scan_res.target;
    store_wr.prio  = scan_req.prio;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // zero result unless a push actually writes a slot
          start_nxt = '0;
          end_nxt   = '0;
          perm_nxt  = '0;
          slot_nxt  = '0;
          en_nxt    = 1'b0;
          found_nxt = 1'b0;
          if (in_cmd == prrs_pkg::CMD_INVAL) begin
            // drop all priorities, rewind the pointer
            store_wr.clear = 1'b1;
            ptr_nxt        = '0;
            state_nxt      = ST_DONE;
          end else if (!HAS_DYN) begin
            state_nxt = ST_DONE;
          end else begin
            start_nxt      = in_region_start;
            end_nxt        = in_region_end;
            perm_nxt       = in_region_perm;
            scan_req.start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        store_wr.prio = prio_hold_r;
        if (scan_res.done) begin
          // commit the slot, advance the pointer past it on a hit only
          store_wr.wr_en = 1'b1;
          if (scan_res.found) begin
            ptr_nxt = prrs_pkg::rel_wrap_inc(scan_res.target, LAST_REL);
          end
          slot_nxt  = SW'(scan_res.target) + FIRST_SLOT;
          en_nxt    = 1'b1;
          found_nxt = scan_res.found;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      prio_hold_r <= prio_eff;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
    perm_r  <= perm_nxt;
    slot_r  <= slot_nxt;
    en_r    <= en_nxt;
    found_r <= found_nxt;
    if (out_load) begin
      out_slot_r  <= slot_r;
      out_start_r <= start_r;
      out_end_r   <= end_r;
      out_perm_r  <= perm_r;
      out_en_r    <= en_r;
      out_found_r <= found_r;
    end
  end

  prrs_prio_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (store_wr),
    .rd_rel  (rd_rel),
    .rd_prio (rd_prio)
  );

  prrs_scan_seq #(
    .DEPTH (STORE_DEPTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (scan_req),
    .rd_prio (rd_prio),
    .rd_rel  (rd_rel),
    .res     (scan_res)
  );

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_start       = out_start_r;
  assign out_end         = out_end_r;
  assign out_perm        = out_perm_r;
  assign out_slot_enable = out_en_r;
  assign out_found_lower = out_found_r;

endmodule

[sim/slot_pick_checker.sv]
// Checker for the priority round-robin slot picker: watches both channels, predicts
// each slot write from its own copy of pointer and priorities, and compares.
// Depends on prrs_pkg for the command codes and field widths.
`timescale 1ns / 100ps

module slot_pick_checker #(
  parameter int FIRST_DYN = 5,
  parameter int TOTAL     = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [prrs_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [prrs_pkg::WORD_W-1:0] in_region_start,
  input  logic [prrs_pkg::WORD_W-1:0] in_region_end,
  input  logic [prrs_pkg::WORD_W-1:0] in_region_perm,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [prrs_pkg::SLOT_W-1:0] out_slot,
  input  logic [prrs_pkg::WORD_W-1:0] out_start,
  input  logic [prrs_pkg::WORD_W-1:0] out_end,
  input  logic [prrs_pkg::WORD_W-1:0] out_perm,
  input  logic                        out_slot_enable,
  input  logic                        out_found_lower,
  output int                          fail_count,
  output int                          pending_count
);

  localparam int SLOT_W = prrs_pkg::SLOT_W;
  localparam int PRIO_W = prrs_pkg::PRIO_W;
  localparam int WORD_W = prrs_pkg::WORD_W;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] start_word;
    logic [WORD_W-1:0] end_word;
    logic [WORD_W-1:0] perm;
    logic              enable;
    logic              found_lower;
  } slot_write_t;

  slot_write_t       expected_writes[$];
  logic [SLOT_W-1:0] next_ptr;
  logic [PRIO_W-1:0] prio_tab[16];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0d ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // scan from the pointer for the first slot of strictly lower priority; invalidate clears all
  function automatic slot_write_t pick_slot(input prrs_pkg::cmd_t c,
                                            input logic [PRIO_W-1:0] req,
                                            input logic [WORD_W-1:0] s,
                                            input logic [WORD_W-1:0] e,
                                            input logic [WORD_W-1:0] p);
    slot_write_t       res;
    int                n;
    int                rel;
    int                scan;
    int                target;
    bit                found;
    logic [PRIO_W-1:0] eff;
    res   = '0;
    n     = (TOTAL > FIRST_DYN) ? TOTAL - FIRST_DYN : 0;
    found = 1'b0;
    if (c == prrs_pkg::CMD_INVAL) begin
      for (int k = 0; k < 16; k++) prio_tab[k] = '0;
      next_ptr = SLOT_W'(FIRST_DYN);
      return res;
    end
    if (n == 0 || n > 16) return res;
    eff = (req == '0) ? PRIO_W'(1) : req;
    rel = (int'(next_ptr) >= FIRST_DYN) ? int'(next_ptr) - FIRST_DYN : 0;
    if (rel >= n) rel = 0;
    // fall back to the slot just before the pointer
    target = (rel == 0) ? n - 1 : rel - 1;
    scan   = rel;
    for (int i = 0; i < n; i++) begin
      if (!found && prio_tab[scan] < eff) begin
        target = scan;
        found  = 1'b1;
      end
      scan = (scan + 1 >= n) ? 0 : scan + 1;
    end
    prio_tab[target] = eff;
    if (found) rel = (target + 1 >= n) ? 0 : target + 1;
    next_ptr = SLOT_W'(rel + FIRST_DYN);
    res.slot        = SLOT_W'(target + FIRST_DYN);
    res.start_word  = s;
    res.end_word    = e;
    res.perm        = p;
    res.enable      = 1'b1;
    res.found_lower = found;
    return res;
  endfunction

  always @(posedge clk) begin
    slot_write_t want;
    if (!rst_n) begin
      next_ptr = SLOT_W'(FIRST_DYN);
      for (int k = 0; k < 16; k++) prio_tab[k] = '0;
      expected_writes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected word, slot", 32'(out_slot), 32'h0);
        end else begin
          want = expected_writes.pop_front();
          if (out_slot !== want.slot)
            report_mismatch("slot", 32'(out_slot), 32'(want.slot));
          if (out_start !== want.start_word)
            report_mismatch("start", out_start, want.start_word);
          if (out_end !== want.end_word)
            report_mismatch("end", out_end, want.end_word);
          if (out_perm !== want.perm)
            report_mismatch("perm", out_perm, want.perm);
          if (out_slot_enable !== want.enable)
            report_mismatch("slot_enable", 32'(out_slot_enable), 32'(want.enable));
          if (out_found_lower !== want.found_lower)
            report_mismatch("found_lower", 32'(out_found_lower), 32'(want.found_lower));
        end
      end
      if (in_valid && !in_stall)
        expected_writes.push_back(pick_slot(prrs_pkg::cmd_t'(in_cmd), in_priority_req,
                                            in_region_start, in_region_end,
                                            in_region_perm));
    end
    pending_count = expected_writes.size();
  end

endmodule

[sim/tb.sv]
// Top of the slot picker testbench: clock, reset, stimulus and the verdict.
// Depends on prrs_pkg, priority_round_robin_region_slots_unit and slot_pick_checker.
`timescale 1ns / 100ps

module tb;

  localparam int SLOT_W = prrs_pkg::SLOT_W;
  localparam int PRIO_W = prrs_pkg::PRIO_W;
  localparam int WORD_W = prrs_pkg::WORD_W;

  localparam int FIRST_DYN  = 5;
  localparam int TOTAL      = 12;
  localparam int RAND_WORDS = 900;
  localparam int CALM_WORDS = 100;      // tail of the run with no idling at all
  localparam int DRAIN_CYC  = 20;
  localparam int LIMIT_CYC  = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [PRIO_W-1:0] in_priority_req;
  logic [WORD_W-1:0] in_region_start;
  logic [WORD_W-1:0] in_region_end;
  logic [WORD_W-1:0] in_region_perm;
  logic              out_valid;
  logic              out_stall;
  logic [SLOT_W-1:0] out_slot;
  logic [WORD_W-1:0] out_start;
  logic [WORD_W-1:0] out_end;
  logic [WORD_W-1:0] out_perm;
  logic              out_slot_enable;
  logic              out_found_lower;

  int fail_count;
  int pending_count;
  int cycle_count;
  bit idle_on;   // enable random gaps on the sender and stalls on the receiver
  int stall_left;

  priority_round_robin_region_slots_unit #(
    .FIRST_DYNAMIC_SLOT(FIRST_DYN),
    .TOTAL_SLOTS       (TOTAL)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_priority_req(in_priority_req),
    .in_region_start(in_region_start),
    .in_region_end  (in_region_end),
    .in_region_perm (in_region_perm),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot       (out_slot),
    .out_start      (out_start),
    .out_end        (out_end),
    .out_perm       (out_perm),
    .out_slot_enable(out_slot_enable),
    .out_found_lower(out_found_lower)
  );

  slot_pick_checker #(
    .FIRST_DYN(FIRST_DYN),
    .TOTAL    (TOTAL)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_priority_req(in_priority_req),
    .in_region_start(in_region_start),
    .in_region_end  (in_region_end),
    .in_region_perm (in_region_perm),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot       (out_slot),
    .out_start      (out_start),
    .out_end        (out_end),
    .out_perm       (out_perm),
    .out_slot_enable(out_slot_enable),
    .out_found_lower(out_found_lower),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bail out if the block hangs: a run that is fine never gets near this.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side: stall in bursts, started at random while idling is enabled.
  // Decide once per falling edge so out_stall gets a single update per step.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    out_stall <= (stall_left > 0);
  end

  // Send one word. Enter and leave at a falling edge. A gap is taken before the
  // word is raised, never in reaction to in_stall, and the payload is held
  // unchanged until the word is taken.
  task automatic send_word(input prrs_pkg::cmd_t c, input logic [PRIO_W-1:0] req,
                           input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] e,
                           input logic [WORD_W-1:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_priority_req <= req;
    in_region_start <= s;
    in_region_end   <= e;
    in_region_perm  <= p;
    // in_stall read right after the edge still holds its value from before it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a priority: mostly a narrow low band so the table fills and the
  // fallback overwrite shows up often, sometimes the top band or anything.
  function automatic logic [PRIO_W-1:0] draw_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return PRIO_W'($urandom_range(0, 6));
    if (r < 80) return PRIO_W'($urandom_range(250, 255));
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int r;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = prrs_pkg::CMD_PUSH;
    in_priority_req = '0;
    in_region_start = '0;
    in_region_end   = '0;
    in_region_perm  = '0;
    idle_on         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;

    // Directed part.
    // Priority 0 counts as 1 and lands in the first dynamic slot; all-zero fields.
    send_word(prrs_pkg::CMD_PUSH, 8'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    // Top priority, all-ones fields.
    send_word(prrs_pkg::CMD_PUSH, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the rest with priority 1; the pointer wraps back to the first slot.
    for (int k = 0; k < TOTAL - FIRST_DYN - 2; k++)
      send_word(prrs_pkg::CMD_PUSH, 8'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'(k));
    // Nothing lower than 1 left: fall back to the slot before the pointer.
    send_word(prrs_pkg::CMD_PUSH, 8'd1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    // Priority 0 behaves the same as 1 here.
    send_word(prrs_pkg::CMD_PUSH, 8'd0, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F);
    // A higher priority finds a lower slot right away.
    send_word(prrs_pkg::CMD_PUSH, 8'd2, 32'h0000_1000, 32'h0000_1FFF, 32'h0000_0007);
    // Invalidate with junk fields: everything comes back 0.
    send_word(prrs_pkg::CMD_INVAL, 8'hFF, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'hFFFF_FFFF);
    // Fill every slot with top priority, then push top priority and priority 0:
    // both overwrite the slot just before the pointer.
    for (int k = 0; k < TOTAL - FIRST_DYN; k++)
      send_word(prrs_pkg::CMD_PUSH, 8'd255, $urandom, $urandom, $urandom);
    send_word(prrs_pkg::CMD_PUSH, 8'd255, 32'h0000_0001, 32'h8000_0000, 32'hF0F0_F0F0);
    send_word(prrs_pkg::CMD_PUSH, 8'd0, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
    // Invalidate twice in a row, then a push right after.
    send_word(prrs_pkg::CMD_INVAL, 8'd0, 32'h0, 32'h0, 32'h0);
    send_word(prrs_pkg::CMD_INVAL, 8'd128, 32'h1, 32'h2, 32'h3);
    send_word(prrs_pkg::CMD_PUSH, 8'd128, 32'h0000_0100, 32'h0000_01FF, 32'h0000_0003);

    // Random part: mostly pushes, an occasional invalidate. Idling runs in
    // stretches, with quiet stretches between and none at the very end.
    for (int k = 0; k < RAND_WORDS; k++) begin
      idle_on = ((k / 100) % 3 != 2) && (k < RAND_WORDS - CALM_WORDS);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_word(prrs_pkg::CMD_INVAL, PRIO_W'($urandom), $urandom, $urandom, $urandom);
      end else begin
        send_word(prrs_pkg::CMD_PUSH, draw_priority(), $urandom, $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;

    // Drain every expected word, then give stray words time to show up.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/prrs_pkg.sv
rtl/prrs_prio_store.sv
rtl/prrs_scan_seq.sv
rtl/priority_round_robin_region_slots_unit.sv
sim/slot_pick_checker.sv
sim/tb.sv
